[src/savgol_fir_three_axis_defines.svh]
// assertion macros shared by the filter modules
// no dependencies; included by the controller and the datapath
`ifndef SAVGOL_FIR_THREE_AXIS_DEFINES_SVH
`define SAVGOL_FIR_THREE_AXIS_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SGF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SGF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/sgf_pkg.sv]
// shared types, constants and the coefficient lookup of the smoothing filter
// no dependencies
package sgf_pkg;

    localparam int COEF_W     = 16;
    localparam int NORM_W     = 16;
    localparam int WIN_W      = 4;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;
    localparam int TAP_IDX_W  = 5;
    localparam int AXES       = 3;

    localparam logic [1:0] REG_WINDOW  = 2'd0;
    localparam logic [1:0] REG_NORM    = 2'd1;
    localparam logic [1:0] REG_COEF_LO = 2'd2;
    localparam logic [1:0] REG_COEF_HI = 2'd3;

    localparam logic [WIN_W-1:0]  WINDOW_RST = 4'd5;
    localparam logic [NORM_W-1:0] NORM_RST   = 16'd35;

    typedef struct packed {
        logic [WIN_W-1:0]      window;
        logic [NORM_W-1:0]     norm;
        logic [CFG_DATA_W-1:0] coef_lo;
        logic [CFG_DATA_W-1:0] coef_hi;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic rd_issue;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic tap_last;
        logic pipe_empty;
        logic div_last;
    } t_sts;

    // taps 8 and above carry no coefficient
    function automatic logic signed [COEF_W-1:0] tap_coef(
        input logic [CFG_DATA_W-1:0] lo,
        input logic [CFG_DATA_W-1:0] hi,
        input logic [TAP_IDX_W-1:0]  idx
    );
        logic [CFG_DATA_W-1:0]    word;
        logic signed [COEF_W-1:0] c;
        word = idx[2] ? hi : lo;
        c = word[{idx[1:0], 4'b0000} +: COEF_W];
        if (idx[TAP_IDX_W-1:3] != '0) begin
            c = '0;
        end
        return c;
    endfunction

endpackage

[src/sgf_if.sv]
// sample and result channel interfaces of the smoothing filter
// no dependencies
interface sgf_in_if #(
    parameter int SAMPLE_BITS = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] in_x;
    logic signed [SAMPLE_BITS-1:0] in_y;
    logic signed [SAMPLE_BITS-1:0] in_z;

    modport source (output valid, output in_x, output in_y, output in_z, input ready);
    modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

interface sgf_out_if #(
    parameter int SAMPLE_BITS = 24
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_x;
    logic signed [SAMPLE_BITS-1:0] out_y;
    logic signed [SAMPLE_BITS-1:0] out_z;
    logic                          warming_up;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output warming_up, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input warming_up, output ready);
endinterface

[src/sgf_cfg.sv]
// apb register bank: window size, norm divisor and the two coefficient words
// depends on sgf_pkg
module sgf_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sgf_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [sgf_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [sgf_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready,
    output sgf_pkg::t_cfg                       o_cfg
);

    logic [sgf_pkg::WIN_W-1:0]      r_window;
    logic [sgf_pkg::NORM_W-1:0]     r_norm;
    logic [sgf_pkg::CFG_DATA_W-1:0] r_coef_lo;
    logic [sgf_pkg::CFG_DATA_W-1:0] r_coef_hi;
    logic [1:0]                     reg_idx;
    logic                           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= sgf_pkg::WINDOW_RST;
            r_norm    <= sgf_pkg::NORM_RST;
            r_coef_lo <= '0;
            r_coef_hi <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                sgf_pkg::REG_WINDOW:  r_window  <= pwdata[sgf_pkg::WIN_W-1:0];
                sgf_pkg::REG_NORM:    r_norm    <= pwdata[sgf_pkg::NORM_W-1:0];
                sgf_pkg::REG_COEF_LO: r_coef_lo <= pwdata;
                sgf_pkg::REG_COEF_HI: r_coef_hi <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            sgf_pkg::REG_WINDOW:  prdata = sgf_pkg::CFG_DATA_W'(r_window);
            sgf_pkg::REG_NORM:    prdata = sgf_pkg::CFG_DATA_W'(r_norm);
            sgf_pkg::REG_COEF_LO: prdata = r_coef_lo;
            sgf_pkg::REG_COEF_HI: prdata = r_coef_hi;
            default:              prdata = '0;
        endcase
    end

    assign o_cfg.window  = r_window;
    assign o_cfg.norm    = r_norm;
    assign o_cfg.coef_lo = r_coef_lo;
    assign o_cfg.coef_hi = r_coef_hi;

endmodule

[src/sgf_ctrl.sv]
// sequencer: sample load, tap loop, pipeline drain, divide and result hand-off
// depends on sgf_pkg and the assertion macro header
`include "savgol_fir_three_axis_defines.svh"

module sgf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output sgf_pkg::t_cmd  o_cmd,
    input  sgf_pkg::t_sts  i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_DRAIN,
        S_DIV,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_cmd.accept   = i_in_valid && o_in_ready;
    assign o_cmd.rd_issue = (r_state == S_MAC);
    assign o_cmd.div_init = (r_state == S_DRAIN) && i_sts.pipe_empty;
    assign o_cmd.div_step = (r_state == S_DIV);
    // the output register frees up in the same cycle it is taken
    assign o_cmd.out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd.accept) r_state <= S_MAC;
                end
                S_MAC: begin
                    if (i_sts.tap_last) r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (i_sts.pipe_empty) r_state <= S_DIV;
                end
                S_DIV: begin
                    if (i_sts.div_last) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_cmd.out_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `SGF_ASSERT_IMPLY(a_load_free, i_clk, i_rst_n, o_cmd.out_load, !r_out_valid || i_out_ready, "result overwritten before taken")
    `SGF_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, o_cmd.accept, r_state == S_MAC, "accepted item did not start the tap loop")
    `SGF_ASSERT_IMPLY(a_valid_from_out, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_OUT, "result raised outside the hand-off state")

endmodule

[src/sgf_dp.sv]
// datapath: sample ring, three multiply-accumulate lanes and three serial dividers
// depends on sgf_pkg and the assertion macro header
`include "savgol_fir_three_axis_defines.svh"

module sgf_dp #(
    parameter int MAX_TAPS    = 8,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sgf_pkg::t_cfg                 i_cfg,
    input  sgf_pkg::t_cmd                 i_cmd,
    output sgf_pkg::t_sts                 o_sts,
    input  logic signed [SAMPLE_BITS-1:0] i_in_x,
    input  logic signed [SAMPLE_BITS-1:0] i_in_y,
    input  logic signed [SAMPLE_BITS-1:0] i_in_z,
    output logic signed [SAMPLE_BITS-1:0] o_out_x,
    output logic signed [SAMPLE_BITS-1:0] o_out_y,
    output logic signed [SAMPLE_BITS-1:0] o_out_z,
    output logic                          o_warming_up
);

    localparam int AXES   = sgf_pkg::AXES;
    localparam int NORM_W = sgf_pkg::NORM_W;
    localparam int SLOT_W = $clog2(MAX_TAPS);
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);
    localparam int PROD_W = SAMPLE_BITS + sgf_pkg::COEF_W;
    localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);
    localparam int QB     = SAMPLE_BITS + 1;
    localparam int HI_W   = ACC_W - QB;
    localparam int REM_W  = NORM_W + 1;
    localparam int DC_W   = $clog2(QB);
    localparam int ROW_W  = AXES * SAMPLE_BITS;
    localparam int BS_W   = SLOT_W + 2;

    // one row holds z, y, x of one sample
    logic [ROW_W-1:0]              r_ring [MAX_TAPS];
    logic [ROW_W-1:0]              r_rdata;

    logic [SLOT_W-1:0]             r_wslot;
    logic [SLOT_W-1:0]             n_wslot;
    logic [SLOT_W-1:0]             r_rslot;
    logic [SLOT_W-1:0]             rslot_inc;
    logic [SLOT_W-1:0]             base_slot;
    logic [BS_W-1:0]               base_sum;
    logic [CNT_W-1:0]              r_fill;
    logic [CNT_W-1:0]              n_fill;
    logic [CNT_W-1:0]              w_eff;
    logic [CNT_W-1:0]              n_cnt;
    logic [CNT_W-1:0]              r_n;
    logic                          r_warm;
    logic                          n_warm;
    logic [NORM_W-1:0]             r_div;
    logic [NORM_W-1:0]             n_div;
    logic [SLOT_W-1:0]             r_tap;
    logic [SLOT_W-1:0]             r_rd_tap;
    logic                          r_rd_vld;
    logic                          r_prod_vld;
    logic [DC_W-1:0]               r_dcnt;

    logic signed [sgf_pkg::COEF_W-1:0] coef;
    logic signed [SAMPLE_BITS-1:0]     lane_s   [AXES];
    logic signed [PROD_W-1:0]          n_prod   [AXES];
    logic signed [PROD_W-1:0]          r_prod   [AXES];
    logic signed [ACC_W-1:0]           r_acc    [AXES];
    logic [ACC_W-1:0]                  mag      [AXES];
    logic                              init_ovf [AXES];
    logic [REM_W-1:0]                  trial    [AXES];
    logic [REM_W-1:0]                  rem_nx   [AXES];
    logic                              q_bit    [AXES];
    logic [REM_W-1:0]                  r_rem    [AXES];
    logic [QB-1:0]                     r_qsh    [AXES];
    logic                              r_neg    [AXES];
    logic                              r_ovf    [AXES];
    logic [SAMPLE_BITS-1:0]            res      [AXES];
    logic [SAMPLE_BITS-1:0]            r_out    [AXES];
    logic                              r_out_warm;
    logic                              rem_ok;

    // load-time bookkeeping: new fill, window clamp, oldest slot, divisor
    always_comb begin
        n_wslot = (r_wslot == SLOT_W'(MAX_TAPS - 1)) ? '0 : r_wslot + 1'b1;
        n_fill  = (r_fill < CNT_W'(MAX_TAPS)) ? r_fill + 1'b1 : r_fill;
        if (i_cfg.window == '0) begin
            w_eff = CNT_W'(1);
        end else if ({2'b00, i_cfg.window} > 6'(MAX_TAPS)) begin
            w_eff = CNT_W'(MAX_TAPS);
        end else begin
            w_eff = CNT_W'(i_cfg.window);
        end
        n_warm   = (n_fill < w_eff);
        n_cnt    = n_warm ? n_fill : w_eff;
        base_sum = BS_W'(n_wslot) + BS_W'(MAX_TAPS) - BS_W'(n_cnt);
        if (base_sum >= BS_W'(MAX_TAPS)) begin
            base_slot = SLOT_W'(base_sum - BS_W'(MAX_TAPS));
        end else begin
            base_slot = SLOT_W'(base_sum);
        end
        if (n_warm) begin
            n_div = NORM_W'(n_cnt);
        end else if (i_cfg.norm == '0) begin
            n_div = NORM_W'(1);
        end else begin
            n_div = i_cfg.norm;
        end
        rslot_inc = (r_rslot == SLOT_W'(MAX_TAPS - 1)) ? '0 : r_rslot + 1'b1;
    end

    // warm-up mean uses unit weights
    always_comb begin
        if (r_warm) begin
            coef = sgf_pkg::COEF_W'(1);
        end else begin
            coef = sgf_pkg::tap_coef(i_cfg.coef_lo, i_cfg.coef_hi,
                                     sgf_pkg::TAP_IDX_W'(r_rd_tap));
        end
        for (int a = 0; a < AXES; a++) begin
            lane_s[a] = r_rdata[a*SAMPLE_BITS +: SAMPLE_BITS];
            n_prod[a] = PROD_W'(coef) * PROD_W'(lane_s[a]);
        end
    end

    // divider lanes work on magnitudes, so the quotient truncates toward zero
    always_comb begin
        rem_ok = 1'b1;
        for (int a = 0; a < AXES; a++) begin
            mag[a]      = r_acc[a][ACC_W-1] ? ACC_W'(-r_acc[a]) : ACC_W'(r_acc[a]);
            init_ovf[a] = (mag[a][ACC_W-1:QB] >= HI_W'(r_div));
            trial[a]    = {r_rem[a][REM_W-2:0], r_qsh[a][QB-1]};
            q_bit[a]    = (trial[a] >= REM_W'(r_div));
            rem_nx[a]   = q_bit[a] ? trial[a] - REM_W'(r_div) : trial[a];
            if (!r_ovf[a] && (r_rem[a] >= REM_W'(r_div))) begin
                rem_ok = 1'b0;
            end
            if (r_neg[a]) begin
                if (r_ovf[a] || (r_qsh[a] > {2'b01, {(SAMPLE_BITS-1){1'b0}}})) begin
                    res[a] = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
                end else begin
                    res[a] = SAMPLE_BITS'(~r_qsh[a] + QB'(1));
                end
            end else begin
                if (r_ovf[a] || (r_qsh[a] > {2'b00, {(SAMPLE_BITS-1){1'b1}}})) begin
                    res[a] = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
                end else begin
                    res[a] = r_qsh[a][SAMPLE_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ring[r_wslot] <= {i_in_z, i_in_y, i_in_x};
        end
        if (i_cmd.rd_issue) begin
            r_rdata <= r_ring[r_rslot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wslot    <= '0;
            r_fill     <= '0;
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_wslot <= n_wslot;
                r_fill  <= n_fill;
            end
            r_rd_vld   <= i_cmd.rd_issue;
            r_prod_vld <= r_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_warm  <= n_warm;
            r_n     <= n_cnt;
            r_div   <= n_div;
            r_rslot <= base_slot;
            r_tap   <= '0;
        end
        if (i_cmd.rd_issue) begin
            r_rslot  <= rslot_inc;
            r_tap    <= r_tap + 1'b1;
            r_rd_tap <= r_tap;
        end
        if (i_cmd.div_init) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + 1'b1;
        end
        for (int a = 0; a < AXES; a++) begin
            if (r_rd_vld) begin
                r_prod[a] <= n_prod[a];
            end
            if (i_cmd.accept) begin
                r_acc[a] <= '0;
            end else if (r_prod_vld) begin
                r_acc[a] <= r_acc[a] + ACC_W'(r_prod[a]);
            end
            // the remainder starts from the high part, which the overflow check keeps below d
            if (i_cmd.div_init) begin
                r_neg[a] <= r_acc[a][ACC_W-1];
                r_ovf[a] <= init_ovf[a];
                r_rem[a] <= REM_W'(mag[a][ACC_W-1:QB]);
                r_qsh[a] <= mag[a][QB-1:0];
            end else if (i_cmd.div_step) begin
                r_rem[a] <= rem_nx[a];
                r_qsh[a] <= {r_qsh[a][QB-2:0], q_bit[a]};
            end
            if (i_cmd.out_load) begin
                r_out[a] <= res[a];
            end
        end
        if (i_cmd.out_load) begin
            r_out_warm <= r_warm;
        end
    end

    assign o_sts.tap_last   = (r_tap == SLOT_W'(r_n - 1'b1));
    assign o_sts.pipe_empty = !r_rd_vld && !r_prod_vld;
    assign o_sts.div_last   = (r_dcnt == DC_W'(QB - 1));

    assign o_out_x      = r_out[0];
    assign o_out_y      = r_out[1];
    assign o_out_z      = r_out[2];
    assign o_warming_up = r_out_warm;

    `SGF_ASSERT_IMPLY(a_tap_in_window, i_clk, i_rst_n, i_cmd.rd_issue, CNT_W'(r_tap) < r_n, "tap read beyond the window")
    `SGF_ASSERT_IMPLY(a_rem_below_div, i_clk, i_rst_n, i_cmd.div_step, rem_ok, "divider remainder not below divisor")
    `SGF_ASSERT_IMPLY(a_fill_bounded, i_clk, i_rst_n, 1'b1, r_fill <= CNT_W'(MAX_TAPS), "fill count beyond ring depth")

endmodule

[src/savgol_fir_three_axis.sv]
// top level of the three-axis smoothing filter: register bank, sequencer and datapath
// depends on sgf_pkg, sgf_in_if, sgf_out_if, sgf_cfg, sgf_ctrl and sgf_dp
//
//   port       role     content
//   i_sample   sink     one x/y/z sample, Q16.8
//   o_result   source   filtered x/y/z, Q16.8 saturated, warming_up flag
//   apb        slave    window_size 0x00, norm_divisor 0x08, coef lo 0x10, coef hi 0x18
//
// an item runs a tap loop over the n taps in use, a pipeline drain, a divide and the hand-off;
// the tap loop reads one ring row per cycle and the dividers give one quotient bit per cycle
// reset is synchronous and active low; the ring holds no reset value and only written
// rows are read
// a result waits in the output register while the next sample is taken in; only a
// result that finds the register still full stalls the sequencer

module savgol_fir_three_axis #(
    parameter int MAX_TAPS    = 8,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    sgf_in_if.sink                             i_sample,
    sgf_out_if.source                          o_result,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sgf_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [sgf_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [sgf_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready
);

    sgf_pkg::t_cfg cfg;
    sgf_pkg::t_cmd cmd;
    sgf_pkg::t_sts sts;

    sgf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sgf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample.valid),
        .o_in_ready  (i_sample.ready),
        .i_out_ready (o_result.ready),
        .o_out_valid (o_result.valid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    sgf_dp #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_in_x       (i_sample.in_x),
        .i_in_y       (i_sample.in_y),
        .i_in_z       (i_sample.in_z),
        .o_out_x      (o_result.out_x),
        .o_out_y      (o_result.out_y),
        .o_out_z      (o_result.out_z),
        .o_warming_up (o_result.warming_up)
    );

endmodule
